// ===== hw/rtl/sddd_pkg.sv =====
// ----------------------------------------------------------------------------
// sddd_pkg - shared types and constants for the date difference unit
// field widths, calendar tables and sequencer state codes
// ----------------------------------------------------------------------------
package sddd_pkg;

  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 14;
  localparam int OUT_W   = 23;
  localparam int ACC_W   = 23;   // unsigned whole-year span, up to 16383 * 366 days
  localparam int DIFF_W  = 25;   // signed working difference before saturation
  localparam int DOY_W   = 9;    // day of year, 1..366

  localparam int YEAR_MAX_DEFAULT = 9999;

  localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);

  localparam logic signed [DIFF_W-1:0] DIFF_HI = DIFF_W'(4194303);
  localparam logic signed [DIFF_W-1:0] DIFF_LO = -DIFF_W'(4194304);

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_YEAR = 3'd1;
  localparam logic [2:0] ST_DAYS = 3'd2;
  localparam logic [2:0] ST_ADJ  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  function automatic logic [DOY_W-1:0] month_start(input logic [MONTH_W-1:0] m);
    logic [DOY_W-1:0] r;
    unique case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] r;
    unique case (m)
      4'd2:                      r = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   r = 5'd30;
      default:                   r = 5'd31;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/signed_date_difference_days_unit.sv =====
// ----------------------------------------------------------------------------
// signed_date_difference_days_unit - signed day count between two dates
// walks the years once with a shared accumulator, then adds day-of-year terms
// ----------------------------------------------------------------------------
// channel | direction | ports
// in      | input     | in_valid, in_ready, in_first_*, in_second_*, in_include_end_day
// out     | output    | out_valid, out_ready, out_day_difference, out_date_invalid
//
// each item walks every year from 1 up to max(first_year, second_year);
// the year walk runs one year per cycle through a single adder
// an invalid month, year or zero day skips the walk and goes straight to output
// in_ready is high only while the sequencer is idle; out stalls hold the result
// rst_n is synchronous, active low, and clears the sequencer and out_valid
module signed_date_difference_days_unit #(
  parameter int YEAR_MAX = sddd_pkg::YEAR_MAX_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [sddd_pkg::DAY_W-1:0]    in_first_day,
  input  logic [sddd_pkg::MONTH_W-1:0]  in_first_month,
  input  logic [sddd_pkg::YEAR_W-1:0]   in_first_year,
  input  logic [sddd_pkg::DAY_W-1:0]    in_second_day,
  input  logic [sddd_pkg::MONTH_W-1:0]  in_second_month,
  input  logic [sddd_pkg::YEAR_W-1:0]   in_second_year,
  input  logic                          in_include_end_day,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [sddd_pkg::OUT_W-1:0] out_day_difference,
  output logic                          out_date_invalid
);
  import sddd_pkg::*;

  localparam logic [YEAR_W:0] YMAX = (YEAR_W+1)'(YEAR_MAX);

  logic [2:0]          state_r, state_nxt;
  logic [DAY_W-1:0]    d1_r, d2_r;
  logic [MONTH_W-1:0]  m1_r, m2_r;
  logic [YEAR_W-1:0]   y1_r, y2_r, ylo_r, yhi_r, yc_r;
  logic                inc_r, neg_r, leap1_r, leap2_r, bad_r;
  logic [1:0]          m4_r;
  logic [6:0]          m100_r;
  logic [8:0]          m400_r;
  logic [ACC_W-1:0]    acc_r;
  logic signed [DIFF_W-1:0] diff_r;
  logic                out_valid_r;
  logic signed [OUT_W-1:0] out_diff_r;
  logic                out_bad_r;

  logic                accept, leap_c, last_year, in_bad, day_bad, out_free;
  logic [DOY_W-1:0]    doy1, doy2;
  logic signed [DIFF_W-1:0] base, adj;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  assign out_valid          = out_valid_r;
  assign out_day_difference = out_diff_r;
  assign out_date_invalid   = out_bad_r;

  // range checks that need no leap-year knowledge
  assign in_bad = (in_first_day == '0) || (in_second_day == '0) ||
                  (in_first_month == '0) || (in_first_month > MONTH_DEC) ||
                  (in_second_month == '0) || (in_second_month > MONTH_DEC) ||
                  (in_first_year == '0) || ({1'b0, in_first_year} > YMAX) ||
                  (in_second_year == '0) || ({1'b0, in_second_year} > YMAX);

  assign leap_c    = ((m4_r == 2'd0) && (m100_r != 7'd0)) || (m400_r == 9'd0);
  assign last_year = (yc_r == yhi_r);

  assign doy1 = month_start(m1_r) + DOY_W'((m1_r > MONTH_FEB) && leap1_r) + DOY_W'(d1_r);
  assign doy2 = month_start(m2_r) + DOY_W'((m2_r > MONTH_FEB) && leap2_r) + DOY_W'(d2_r);
  assign day_bad = (d1_r > month_len(m1_r, leap1_r)) || (d2_r > month_len(m2_r, leap2_r));

  assign base = neg_r ? -$signed({2'b00, acc_r}) : $signed({2'b00, acc_r});
  assign adj  = !inc_r ? diff_r : (diff_r[DIFF_W-1] ? diff_r - DIFF_W'(1)
                                                    : diff_r + DIFF_W'(1));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = in_bad ? ST_OUT : ST_YEAR;
      ST_YEAR: if (last_year) state_nxt = ST_DAYS;
      ST_DAYS: state_nxt = ST_ADJ;
      ST_ADJ:  state_nxt = ST_OUT;
      ST_OUT:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          d1_r   <= in_first_day;
          m1_r   <= in_first_month;
          y1_r   <= in_first_year;
          d2_r   <= in_second_day;
          m2_r   <= in_second_month;
          y2_r   <= in_second_year;
          inc_r  <= in_include_end_day;
          bad_r  <= in_bad;
          neg_r  <= in_first_year > in_second_year;
          ylo_r  <= (in_first_year > in_second_year) ? in_second_year : in_first_year;
          yhi_r  <= (in_first_year > in_second_year) ? in_first_year : in_second_year;
          yc_r   <= YEAR_W'(1);
          m4_r   <= 2'd1;
          m100_r <= 7'd1;
          m400_r <= 9'd1;
          acc_r  <= '0;
          diff_r <= '0;
        end
      end
      ST_YEAR: begin
        // whole years in [ylo, yhi) add to the span
        if (yc_r >= ylo_r && !last_year) begin
          acc_r <= acc_r + (leap_c ? ACC_W'(366) : ACC_W'(365));
        end
        if (yc_r == y1_r) leap1_r <= leap_c;
        if (yc_r == y2_r) leap2_r <= leap_c;
        yc_r   <= yc_r + YEAR_W'(1);
        m4_r   <= m4_r + 2'd1;
        m100_r <= (m100_r == 7'd99)  ? 7'd0 : m100_r + 7'd1;
        m400_r <= (m400_r == 9'd399) ? 9'd0 : m400_r + 9'd1;
      end
      ST_DAYS: begin
        bad_r  <= day_bad;
        diff_r <= base + DIFF_W'(doy2) - DIFF_W'(doy1);
      end
      ST_ADJ: begin
        if (adj > DIFF_HI) begin
          diff_r <= DIFF_HI;
        end else if (adj < DIFF_LO) begin
          diff_r <= DIFF_LO;
        end else begin
          diff_r <= adj;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_bad_r  <= bad_r;
          out_diff_r <= bad_r ? '0 : diff_r[OUT_W-1:0];
        end
      end
      default: ;
    endcase
  end

endmodule
